@@ design/bbd_pkg.sv @@
// ----------------------------------------------------------------------------
// bbd_pkg
// Types, register indexes and rounding helpers for the Bayer demosaic.
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned FW_W    = 12;
  localparam int unsigned FH_W    = 16;
  localparam int unsigned CFG_W   = 16;

  // 1/6 as 14-bit fraction over 2^16, exact for dividends below 1536
  localparam logic [13:0] RECIP6  = 14'd10923;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_ROWS,
    ST_READ,
    ST_AVG
  } st_e;

  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
    logic last;
    logic odd_row;
    logic odd_col;
  } pix_flags_t;

  // (2*sum + cnt) / (2*cnt), cnt in 0..4
  function automatic logic [PIX_W-1:0] avg_round(logic [9:0] sum, logic [2:0] cnt);
    logic [10:0] x;
    logic [24:0] p;
    logic [10:0] s1;
    logic [10:0] s2;
    x  = {sum, 1'b0} + 11'd3;
    p  = 25'(x) * 25'(RECIP6);
    s1 = (11'(sum) + 11'd1) >> 1;
    s2 = (11'(sum) + 11'd2) >> 2;
    unique case (cnt)
      3'd1:    return sum[PIX_W-1:0];
      3'd2:    return s1[PIX_W-1:0];
      3'd3:    return p[23:16];
      3'd4:    return s2[PIX_W-1:0];
      default: return '0;
    endcase
  endfunction

endpackage

@@ design/bayer_bilinear_demosaic.sv @@
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic
// Bilinear GBRG demosaic over a circular sample history held in one RAM.
// ----------------------------------------------------------------------------
// Input stream: tdata carries the raw 8-bit sample, tuser the kind (0 = sample,
// 1 = drain tick). Samples arrive in raster order. Output stream: tdata holds
// red, green, blue; tlast marks the bottom right pixel of a frame.
// Pixels lag the samples by one row plus one pixel; after the last sample of a
// frame, send width+1 drain ticks to flush the tail. Ticks sent while the frame
// is incomplete or nothing is pending are dropped.
// A sample that yields no pixel leaves the input ready for the next sample. A
// request that yields a pixel holds the input while the 3x3 neighborhood is
// fetched from the single history RAM over two read ports in five read slots,
// then averaged and registered.
// The output register decouples the sides: a finished pixel waits there while
// the next request is taken; a further pixel holds in the averaging step until
// the receiver takes the waiting one.
// Reset clears the counters, the sequencer and the output valid; sizes return
// to 640 x 480. The history RAM is not cleared. The user writes sizes on the
// cfg port while no pixel is being produced; the block does not enforce it.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic
  import bbd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // [7:0] raw_sample
  input  logic              s_axis_tuser_i,   // [0] mode
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [23:0]       m_axis_tdata_o,   // [7:0] red, [15:8] green, [23:16] blue
  output logic              m_axis_tlast_o    // frame_end
);

  localparam int unsigned HIST_LEN = 2 * MAX_WIDTH + 9;
  localparam int unsigned AW = $clog2(HIST_LEN);
  localparam int unsigned EW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = $clog2(MAX_WIDTH + 3);
  localparam logic [AW-1:0] HIST_LAST = AW'(HIST_LEN - 1);

  function automatic logic [AW-1:0] inc_wrap(logic [AW-1:0] a);
    return (a == HIST_LAST) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] dec_wrap(logic [AW-1:0] a);
    return (a == '0) ? HIST_LAST : a - AW'(1);
  endfunction

  function automatic logic [AW-1:0] step_addr(logic [AW-1:0] a, logic [1:0] d);
    unique case (d)
      2'd1:    return inc_wrap(a);
      2'd2:    return dec_wrap(a);
      default: return a;
    endcase
  endfunction

  localparam logic [1:0] D_ZERO = 2'd0;
  localparam logic [1:0] D_INC  = 2'd1;
  localparam logic [1:0] D_DEC  = 2'd2;

  st_e                state_q, state_d;
  logic [FW_W-1:0]    frame_width_q;
  logic [FH_W-1:0]    frame_height_q;
  logic [CW-1:0]      in_col_q, in_col_d, out_col_q, out_col_d;
  logic [FH_W-1:0]    in_row_q, in_row_d, out_row_q, out_row_d;
  logic [PW-1:0]      pend_q, pend_d;
  logic [AW-1:0]      wr_pos_q, wr_pos_d;
  logic [2:0]         step_q;

  logic [AW-1:0]      base_q, upb_q, dnb_q;
  pix_flags_t         flg_q;
  logic [PIX_W-1:0]   own_q;
  logic [8:0]         vs_q, hs_q;
  logic [9:0]         ds_q;

  logic               out_valid_q;
  logic [23:0]        out_data_q;
  logic               out_last_q;

  logic [EW-1:0]      eff_w;
  logic [FH_W-1:0]    eff_h;
  logic               in_acc, emit_go, out_free, out_load, mem_we;
  logic [AW-1:0]      rd_addr_a, rd_addr_b;
  logic [PIX_W-1:0]   rd_a_q, rd_b_q;
  logic [PIX_W-1:0]   hist_mem [HIST_LEN];

  // effective sizes
  always_comb begin
    if (frame_width_q == '0) begin
      eff_w = EW'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(frame_width_q);
    end
    eff_h = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;
  end

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign emit_go  = in_acc && (!s_axis_tuser_i ? (pend_q > PW'(eff_w))
                    : (pend_q != '0 && in_col_q == '0 && in_row_q == '0));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (emit_go) state_d = ST_BASE;
      ST_BASE: state_d = ST_ROWS;
      ST_ROWS: state_d = ST_READ;
      ST_READ: if (step_q == 3'd5) state_d = ST_AVG;
      ST_AVG:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_AVG:  out_load = out_free;
      default: ;
    endcase
  end

  assign mem_we = in_acc && !s_axis_tuser_i;

  // counters
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pend_d    = pend_q;
    wr_pos_d  = wr_pos_q;
    if (mem_we) begin
      wr_pos_d = inc_wrap(wr_pos_q);
      pend_d   = pend_q + PW'(1);
      if ((EW + 1)'(in_col_q) + (EW + 1)'(1) >= (EW + 1)'(eff_w)) begin
        in_col_d = '0;
        in_row_d = ((FH_W + 1)'(in_row_q) + 17'd1 >= (FH_W + 1)'(eff_h)) ? '0
                   : in_row_q + FH_W'(1);
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
    end
    if (out_load) begin
      pend_d = pend_q - PW'(1);
      if ((EW + 1)'(out_col_q) + (EW + 1)'(1) >= (EW + 1)'(eff_w)) begin
        out_col_d = '0;
        out_row_d = ((FH_W + 1)'(out_row_q) + 17'd1 >= (FH_W + 1)'(eff_h)) ? '0
                    : out_row_q + FH_W'(1);
      end else begin
        out_col_d = out_col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      frame_width_q  <= FW_W'(640);
      frame_height_q <= FH_W'(480);
      in_col_q       <= '0;
      in_row_q       <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
      pend_q         <= '0;
      wr_pos_q       <= '0;
      step_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pend_q    <= pend_d;
      wr_pos_q  <= wr_pos_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
          REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_READ) begin
        step_q <= step_q + 3'd1;
      end else begin
        step_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // read address pairs per slot
  always_comb begin
    rd_addr_a = base_q;
    rd_addr_b = base_q;
    unique case (step_q)
      3'd0: begin
        rd_addr_a = base_q;
        rd_addr_b = step_addr(base_q, D_DEC);
      end
      3'd1: begin
        rd_addr_a = step_addr(base_q, D_INC);
        rd_addr_b = upb_q;
      end
      3'd2: begin
        rd_addr_a = dnb_q;
        rd_addr_b = step_addr(upb_q, D_DEC);
      end
      3'd3: begin
        rd_addr_a = step_addr(upb_q, D_INC);
        rd_addr_b = step_addr(dnb_q, D_DEC);
      end
      3'd4: begin
        rd_addr_a = step_addr(dnb_q, D_INC);
        rd_addr_b = step_addr(base_q, D_ZERO);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[wr_pos_q] <= s_axis_tdata_i;
    end
    rd_a_q <= hist_mem[rd_addr_a];
    rd_b_q <= hist_mem[rd_addr_b];
  end

  // datapath
  logic [AW:0]      base_sum;
  logic [AW:0]      up_sum, dn_sum;
  logic [1:0]       vn, hn;
  logic [2:0]       dnum;
  logic [PIX_W-1:0] va, ha, da, ga, red, grn, blu;

  always_comb begin
    if (wr_pos_q >= AW'(pend_q)) begin
      base_sum = (AW + 1)'(wr_pos_q) - (AW + 1)'(pend_q);
    end else begin
      base_sum = (AW + 1)'(wr_pos_q) + (AW + 1)'(HIST_LEN) - (AW + 1)'(pend_q);
    end
    if (base_q >= AW'(eff_w)) begin
      up_sum = (AW + 1)'(base_q) - (AW + 1)'(eff_w);
    end else begin
      up_sum = (AW + 1)'(base_q) + (AW + 1)'(HIST_LEN) - (AW + 1)'(eff_w);
    end
    dn_sum = (AW + 1)'(base_q) + (AW + 1)'(eff_w);
    if (dn_sum >= (AW + 1)'(HIST_LEN)) begin
      dn_sum = dn_sum - (AW + 1)'(HIST_LEN);
    end
  end

  always_comb begin
    vn   = {1'b0, flg_q.up} + {1'b0, flg_q.dn};
    hn   = {1'b0, flg_q.lf} + {1'b0, flg_q.rt};
    dnum = 3'(vn) * 3'(hn);
    va   = avg_round(10'(vs_q), 3'(vn));
    ha   = avg_round(10'(hs_q), 3'(hn));
    da   = avg_round(ds_q, dnum);
    ga   = avg_round(10'(vs_q) + 10'(hs_q), 3'(vn) + 3'(hn));
    if (flg_q.odd_row == flg_q.odd_col) begin
      grn = own_q;
      red = flg_q.odd_row ? ha : va;
      blu = flg_q.odd_row ? va : ha;
    end else begin
      grn = ga;
      red = flg_q.odd_row ? own_q : da;
      blu = flg_q.odd_row ? da : own_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_BASE) begin
      base_q        <= base_sum[AW-1:0];
      flg_q.up      <= out_row_q != '0;
      flg_q.dn      <= (FH_W + 1)'(out_row_q) + 17'd1 < (FH_W + 1)'(eff_h);
      flg_q.lf      <= out_col_q != '0;
      flg_q.rt      <= (EW + 1)'(out_col_q) + (EW + 1)'(1) < (EW + 1)'(eff_w);
      flg_q.last    <= ((FH_W + 1)'(out_row_q) + 17'd1 == (FH_W + 1)'(eff_h)) &&
                       ((EW + 1)'(out_col_q) + (EW + 1)'(1) == (EW + 1)'(eff_w));
      flg_q.odd_row <= out_row_q[0];
      flg_q.odd_col <= out_col_q[0];
    end
    if (state_q == ST_ROWS) begin
      upb_q <= up_sum[AW-1:0];
      dnb_q <= dn_sum[AW-1:0];
    end
    if (state_q == ST_READ) begin
      unique case (step_q)
        3'd1: begin
          own_q <= rd_a_q;
          vs_q  <= '0;
          ds_q  <= '0;
          hs_q  <= flg_q.lf ? 9'(rd_b_q) : '0;
        end
        3'd2: begin
          if (flg_q.rt) hs_q <= hs_q + 9'(rd_a_q);
          if (flg_q.up) vs_q <= vs_q + 9'(rd_b_q);
        end
        3'd3: begin
          if (flg_q.dn) vs_q <= vs_q + 9'(rd_a_q);
          if (flg_q.up && flg_q.lf) ds_q <= ds_q + 10'(rd_b_q);
        end
        3'd4: begin
          ds_q <= ds_q + ((flg_q.up && flg_q.rt) ? 10'(rd_a_q) : '0)
                       + ((flg_q.dn && flg_q.lf) ? 10'(rd_b_q) : '0);
        end
        3'd5: begin
          if (flg_q.dn && flg_q.rt) ds_q <= ds_q + 10'(rd_a_q);
        end
        default: ;
      endcase
    end
    if (out_load) begin
      out_data_q <= {blu, grn, red};
      out_last_q <= flg_q.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  a_base_to_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BASE |=> state_q == ST_ROWS)
    else $error("address setup did not follow base step");

  a_read_to_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ && step_q == 3'd5) |=> state_q == ST_AVG)
    else $error("read slots did not end in averaging");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pend_q) <= MAX_WIDTH + 2)
    else $error("pending count beyond history span");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (state_q == ST_IDLE && out_valid_q))
    else $error("pixel load did not return to idle with valid output");

endmodule

@@ test/bayer_bilinear_demosaic_tb.sv @@
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_tb
// Self-checking bench for the GBRG bilinear demosaic. A queue-fed driver
// sends raw samples and drain ticks in frames of assorted sizes, and an
// in-bench predictor of the sample history works out every RGB pixel. A
// monitor compares each pixel taken from the output stream with the oldest
// prediction. Both sides stall at random, and sizes change between frames.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_tb
  import bbd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W     = 2048;
  localparam int HIST_LEN  = 2 * MAX_W + 9;
  localparam int ITEMS     = 1850;
  localparam int SETTLE    = 24;

  typedef struct packed {
    logic       mode;
    logic [7:0] sample;
  } raw_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pixel_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic              cfg_index_i     = 1'b0;
  logic [CFG_W-1:0]  cfg_data_i      = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [7:0]        s_axis_tdata_i  = '0;
  logic              s_axis_tuser_i  = 1'b0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [23:0]       m_axis_tdata_o;
  logic              m_axis_tlast_o;

  bayer_bilinear_demosaic u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  raw_item_t   raw_q[$];
  pixel_t      pixel_q[$];
  int unsigned n_err         = 0;
  int unsigned fed_cnt       = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // predictor state
  logic [7:0]   pix_hist [HIST_LEN];
  logic [11:0]  cfg_width  = 12'd640;
  logic [15:0]  cfg_height = 16'd480;
  int unsigned  hist_wr  = 0;
  int unsigned  pend_cnt = 0;
  int unsigned  in_col   = 0;
  int unsigned  in_row   = 0;
  int unsigned  out_col  = 0;
  int unsigned  out_row  = 0;

  initial begin
    for (int i = 0; i < HIST_LEN; i++) pix_hist[i] = '0;
  end

  function automatic int unsigned width_eff();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_W) return MAX_W;
    return cfg_width;
  endfunction

  function automatic int unsigned height_eff();
    return (cfg_height == 0) ? 1 : cfg_height;
  endfunction

  function automatic int unsigned avg_half_up(int unsigned sum, int unsigned n);
    if (n == 0) return 0;
    return (2 * sum + n) / (2 * n);
  endfunction

  function automatic void step_pos(inout int unsigned col, inout int unsigned row,
                                   input int unsigned w, input int unsigned h);
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endfunction

  function automatic pixel_t demosaic_pixel();
    int unsigned w, h, r, c, v, own, va, ha, dg;
    int unsigned vs, vn, hs, hn, ds, dnm;
    int          base, a;
    bit          up, dn, lf, rt, okr, okc;
    pixel_t      px;
    w = width_eff();
    h = height_eff();
    r = out_row;
    c = out_col;
    base = (hist_wr + HIST_LEN - pend_cnt) % HIST_LEN;
    vs = 0; vn = 0; hs = 0; hn = 0; ds = 0; dnm = 0;
    up = r > 0;
    dn = r + 1 < h;
    lf = c > 0;
    rt = c + 1 < w;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        okr = (dr < 0) ? up : ((dr > 0) ? dn : 1'b1);
        okc = (dc < 0) ? lf : ((dc > 0) ? rt : 1'b1);
        if (okr && okc && !(dr == 0 && dc == 0)) begin
          a = (base + 2 * HIST_LEN + dr * int'(w) + dc) % HIST_LEN;
          v = pix_hist[a];
          if (dc == 0) begin
            vs += v; vn++;
          end else if (dr == 0) begin
            hs += v; hn++;
          end else begin
            ds += v; dnm++;
          end
        end
      end
    end
    own = pix_hist[base];
    if (((r ^ c) & 1) == 0) begin
      va = avg_half_up(vs, vn);
      ha = avg_half_up(hs, hn);
      px.green = own[7:0];
      px.red   = ((r & 1) == 0) ? va[7:0] : ha[7:0];
      px.blue  = ((r & 1) == 0) ? ha[7:0] : va[7:0];
    end else begin
      dg = avg_half_up(ds, dnm);
      px.green = 8'(avg_half_up(vs + hs, vn + hn));
      px.red   = ((r & 1) == 0) ? dg[7:0] : own[7:0];
      px.blue  = ((r & 1) == 0) ? own[7:0] : dg[7:0];
    end
    px.frame_end = (r + 1 == h) && (c + 1 == w);
    step_pos(out_col, out_row, w, h);
    return px;
  endfunction

  function automatic void demosaic_accept(raw_item_t it);
    int unsigned w, h;
    w = width_eff();
    h = height_eff();
    if (!it.mode) begin
      pix_hist[hist_wr] = it.sample;
      hist_wr = (hist_wr + 1) % HIST_LEN;
      step_pos(in_col, in_row, w, h);
      pend_cnt++;
      if (pend_cnt > w + 1) begin
        pixel_q = {pixel_q, demosaic_pixel()};
        pend_cnt--;
      end
    end else if (pend_cnt > 0 && in_col == 0 && in_row == 0) begin
      pixel_q = {pixel_q, demosaic_pixel()};
      pend_cnt--;
    end
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        demosaic_accept(raw_q.pop_front());
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (raw_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= raw_q[0].sample;
          s_axis_tuser_i  <= raw_q[0].mode;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel: tdata %06h tlast %0b", m_axis_tdata_o, m_axis_tlast_o);
          n_err++;
        end else begin
          want = pixel_q.pop_front();
          if (m_axis_tdata_o[7:0] !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, m_axis_tdata_o[7:0]);
            n_err++;
          end
          if (m_axis_tdata_o[15:8] !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, m_axis_tdata_o[15:8]);
            n_err++;
          end
          if (m_axis_tdata_o[23:16] !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, m_axis_tdata_o[23:16]);
            n_err++;
          end
          if (m_axis_tlast_o !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, m_axis_tlast_o);
            n_err++;
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [7:0] rand_sample();
    unique case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void push_sample(logic [7:0] v);
    raw_item_t it;
    it.mode   = 1'b0;
    it.sample = v;
    raw_q = {raw_q, it};
  endfunction

  function automatic void push_tick();
    raw_item_t it;
    it.mode   = 1'b1;
    it.sample = 8'($urandom_range(255));
    raw_q = {raw_q, it};
  endfunction

  task automatic wait_idle();
    while (raw_q.size() != 0 || pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_size(reg_idx_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_FRAME_WIDTH) cfg_width = val[11:0];
    else cfg_height = val;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h);
    wait_idle();
    write_size(REG_FRAME_WIDTH, CFG_W'(w));
    write_size(REG_FRAME_HEIGHT, CFG_W'(h));
  endtask

  function automatic void push_frame(int unsigned w, int unsigned h);
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < 5) push_tick();
      push_sample(rand_sample());
      fed_cnt++;
    end
  endfunction

  // frames back to back; each tail between them is drained in full, in part or not at all, the last one in full
  task automatic run_frames(int unsigned w, int unsigned h, int unsigned n);
    int unsigned d;
    set_frame(w, h);
    for (int unsigned f = 0; f < n; f++) begin
      push_frame(w, h);
      d = (f + 1 == n) ? w + 1 : $urandom_range(w + 1);
      repeat (d) push_tick();
      fed_cnt += d;
    end
    repeat ($urandom_range(2)) push_tick();
  endtask

  task automatic pick_idling();
    if (fed_cnt < ITEMS / 3) begin
      send_idle_pct = 21;
      recv_idle_pct = 52;
    end else if (fed_cnt < 2 * ITEMS / 3) begin
      send_idle_pct = 52;
      recv_idle_pct = 21;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  initial begin
    int unsigned w, h;
    bit          wide_done;
    wide_done = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    pick_idling();

    // smallest frame, extreme samples, ticks with nothing pending and mid-frame
    set_frame(2, 2);
    push_tick();
    push_sample(8'hFF);
    push_sample(8'h00);
    push_tick();
    push_sample(8'h00);
    push_sample(8'hFF);
    repeat (4) push_tick();

    // two 3x2 frames back to back, tail flushed by the second frame
    set_frame(3, 2);
    push_sample(8'h00); push_sample(8'hFF); push_sample(8'hFF);
    push_sample(8'hFF); push_sample(8'h00); push_sample(8'h00);
    push_sample(8'hFF); push_sample(8'h00); push_sample(8'h00);
    push_sample(8'h00); push_sample(8'hFF); push_sample(8'hFF);
    repeat (5) push_tick();

    while (fed_cnt < ITEMS) begin
      pick_idling();
      if (!wide_done && fed_cnt >= ITEMS / 3) begin
        run_frames(MAX_W / 8, 2, 1);
        wide_done = 1'b1;
      end
      w = ($urandom_range(99) < 75) ? $urandom_range(2, 8) : $urandom_range(9, 48);
      h = ($urandom_range(99) < 80) ? $urandom_range(2, 5) : $urandom_range(6, 10);
      run_frames(w, h, $urandom_range(1, 3));
    end

    // tallest frame, only its first rows
    set_frame(2, 16'hFFFF);
    repeat (40) push_sample(rand_sample());
    wait_idle();

    if (n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
